@@ sv/utf8d_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared types, constants and helpers for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

  localparam int unsigned CpW      = 31;
  localparam int unsigned QDepth   = 4;
  localparam int unsigned QPtrW    = $clog2(QDepth);
  localparam int unsigned QCntW    = QPtrW + 1;

  localparam logic [CpW-1:0] CpRepl     = 31'h0000_FFFD;
  localparam logic [CpW-1:0] CpMinMulti = 31'h0000_00A0;
  localparam logic [CpW-1:0] CpBom      = 31'h0000_FEFF;
  localparam logic [CpW-1:0] CpSurrLo   = 31'h0000_D800;
  localparam logic [CpW-1:0] CpSurrHi   = 31'h0000_DFFF;
  localparam logic [CpW-1:0] CpTrailLo  = 31'h0000_DC00;
  localparam logic [CpW-1:0] CpPlane1   = 31'h0001_0000;

  // Results raised by one input word, in delivery order.
  typedef struct packed {
    logic [1:0]     n;
    logic [CpW-1:0] cp0;
    logic [CpW-1:0] cp1;
  } utf8d_res_t;

  // One queued output word.
  typedef struct packed {
    logic [CpW-1:0] cp;
    logic           last;
  } utf8d_ent_t;

  // Append one code point to the result list.
  function automatic utf8d_res_t utf8d_push(utf8d_res_t r, logic [CpW-1:0] cp);
    utf8d_res_t o;
    o = r;
    if (r.n == 2'd0) begin
      o.cp0 = cp;
    end else begin
      o.cp1 = cp;
    end
    o.n = r.n + 2'd1;
    return o;
  endfunction

endpackage

@@ sv/utf8_stream_decoder_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_decoder_top
// Byte-wide UTF-8 decoder with surrogate pairing and a small output queue.
// ----------------------------------------------------------------------------
// A result is written into the output queue when its byte word is accepted.
// Throughput: one byte word per cycle while the input is not stalled; a byte
//   raising two results needs two output words, and the four-entry output queue absorbs the difference.
// Input stalls while fewer than two queue entries are free.
// Reset (asynchronous, active low) clears decode state and empties the queue.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_top import utf8d_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  // byte input
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [7:0]     data_byte_i,
  input  logic           end_of_text_i,
  // code point output
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [CpW-1:0] code_point_o,
  output logic           last_in_run_o
);

  logic       in_acc;
  logic       out_acc;
  utf8d_res_t res;
  logic [1:0] n_push;

  // output queue
  utf8d_ent_t           q_mem_q [QDepth];
  logic [QPtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]     cnt_q, cnt_d;
  utf8d_ent_t           ent0, ent1;
  logic [QPtrW-1:0]     wr_ptr_p1;

  // Stall needs room for two words; depends only on queue fill.
  assign in_stall_o = (cnt_q > QCntW'(QDepth - 2));
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_valid_o = (cnt_q != '0);
  assign out_acc    = out_valid_o && !out_stall_i;

  utf8d_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (in_acc),
    .data_byte_i   (data_byte_i),
    .end_of_text_i (end_of_text_i),
    .res_o         (res)
  );

  assign n_push    = in_acc ? res.n : 2'd0;
  // The final result of a byte carries the run-end flag.
  assign ent0      = '{cp: res.cp0, last: (res.n == 2'd1)};
  assign ent1      = '{cp: res.cp1, last: 1'b1};
  assign wr_ptr_p1 = wr_ptr_q + QPtrW'(1);

  always_comb begin
    wr_ptr_d = wr_ptr_q + QPtrW'(n_push);
    rd_ptr_d = rd_ptr_q + QPtrW'(out_acc);
    cnt_d    = cnt_q + QCntW'(n_push) - QCntW'(out_acc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue payload, no reset needed.
  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) q_mem_q[wr_ptr_q] <= ent0;
    if (n_push == 2'd2) q_mem_q[wr_ptr_p1] <= ent1;
  end

  assign code_point_o  = q_mem_q[rd_ptr_q].cp;
  assign last_in_run_o = q_mem_q[rd_ptr_q].last;

endmodule

@@ sv/utf8d_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8d_core
// Decode state and per-byte decision logic; yields up to two code points.
// ----------------------------------------------------------------------------
module utf8d_core import utf8d_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_text_i,
  output utf8d_res_t res_o
);

  logic [2:0]     pend_q, pend_d;
  logic [CpW-1:0] part_q, part_d;
  logic [15:0]    held_q, held_d;

  logic           pending;
  logic [CpW-1:0] acc;
  logic [CpW-1:0] fin;
  logic [CpW-1:0] pair;
  utf8d_res_t     res;

  assign pending = (pend_q != 3'd0);
  assign acc     = {part_q[CpW-7:0], data_byte_i[5:0]};
  assign fin     = (acc < CpMinMulti) ? CpRepl : acc;
  // Held lead is either zero or a valid lead surrogate, so a pair is valid iff held.
  assign pair    = CpW'({held_q[9:0], fin[9:0]}) + CpPlane1;

  always_comb begin
    res    = '0;
    pend_d = pend_q;
    part_d = part_q;
    held_d = held_q;
    if (end_of_text_i || (data_byte_i == 8'h00)) begin
      if (pending) res = utf8d_push(res, CpRepl);
      pend_d = '0;
      part_d = '0;
      held_d = '0;
    end else if (!data_byte_i[7]) begin
      if (pending) res = utf8d_push(res, CpRepl);
      res    = utf8d_push(res, CpW'(data_byte_i));
      pend_d = '0;
    end else if (pending && (data_byte_i[7:6] == 2'b10)) begin
      part_d = acc;
      pend_d = pend_q - 3'd1;
      if (pend_q == 3'd1) begin
        if (fin == CpBom) begin
          res = res;
        end else if ((fin >= CpSurrLo) && (fin <= CpSurrHi)) begin
          if (fin < CpTrailLo) begin
            held_d = fin[15:0];
          end else begin
            held_d = '0;
            res    = utf8d_push(res, (held_q != 16'd0) ? pair : CpRepl);
          end
        end else begin
          res = utf8d_push(res, fin);
        end
      end
    end else begin
      if (pending) res = utf8d_push(res, CpRepl);
      unique casez (data_byte_i)
        8'b110?_???? : begin pend_d = 3'd1; part_d = CpW'(data_byte_i[4:0]); end
        8'b1110_???? : begin pend_d = 3'd2; part_d = CpW'(data_byte_i[3:0]); end
        8'b1111_0??? : begin pend_d = 3'd3; part_d = CpW'(data_byte_i[2:0]); end
        8'b1111_10?? : begin pend_d = 3'd4; part_d = CpW'(data_byte_i[1:0]); end
        8'b1111_110? : begin pend_d = 3'd5; part_d = CpW'(data_byte_i[0]);   end
        default : begin
          res    = utf8d_push(res, CpRepl);
          pend_d = '0;
        end
      endcase
    end
  end

  assign res_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      part_q <= '0;
      held_q <= '0;
    end else if (accept_i) begin
      pend_q <= pend_d;
      part_q <= part_d;
      held_q <= held_d;
    end
  end

endmodule

@@ sv/utf8d_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8d_checker
// Port-level checks for the UTF-8 stream decoder, bound to the top level.
// ----------------------------------------------------------------------------
module utf8d_checker import utf8d_pkg::*; (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input logic [7:0]     data_byte_i,
  input logic           end_of_text_i,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input logic [CpW-1:0] code_point_o,
  input logic           last_in_run_o
);

  // Reset empties the output queue at once.
  a_rst_empty: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

  // A stalled output word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(code_point_o)
      && $stable(last_in_run_o))
    else $error("stalled output word changed");

  // An ASCII byte taken into an empty queue shows up on the next cycle.
  a_ascii_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !end_of_text_i && !data_byte_i[7]
      && (data_byte_i != 8'h00) && !out_valid_o |=> out_valid_o)
    else $error("ASCII byte produced no output");

  // Never zero, overlong C1 range, surrogate or byte-order mark.
  a_cp_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (code_point_o != '0)
      && !((code_point_o >= 31'h80) && (code_point_o < CpMinMulti))
      && !((code_point_o >= CpSurrLo) && (code_point_o <= CpSurrHi))
      && (code_point_o != CpBom))
    else $error("illegal code point emitted");

endmodule

bind utf8_stream_decoder_top utf8d_checker u_utf8d_checker (.*);

@@ verif/utf8_stream_decoder_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_decoder_top_test
// Self-checking bench for the UTF-8 stream decoder: byte words go in under
// bursty valid, code point words come out under a shifting stall pattern,
// and a scoreboard class predicts and compares every code point word.
// ----------------------------------------------------------------------------
import utf8d_pkg::*;

class cp_scoreboard;
  utf8d_ent_t     expected_q[$];
  utf8d_ent_t     run_q[$];
  logic [2:0]     cont_left;
  logic [CpW-1:0] acc;
  logic [15:0]    lead_surr;
  int unsigned    fail_count;

  function new();
    clear_decode();
    fail_count = 0;
  endfunction

  function void clear_decode();
    cont_left = '0;
    acc       = '0;
    lead_surr = '0;
  endfunction

  function void add(logic [CpW-1:0] cp);
    utf8d_ent_t w;
    w.cp   = cp;
    w.last = 1'b0;
    run_q.push_back(w);
  endfunction

  function int unsigned outstanding();
    return expected_q.size();
  endfunction

  // Predict the code point words raised by one accepted byte word.
  function void note_byte(logic [7:0] b, logic eot);
    logic [CpW-1:0] c;
    longint         v;
    run_q.delete();
    if (eot || b == 8'h00) begin
      if (cont_left != 0) add(CpRepl);
      clear_decode();
    end else if (b <= 8'h7F) begin
      if (cont_left != 0) add(CpRepl);
      cont_left = '0;
      add({{(CpW-8){1'b0}}, b});
    end else if (cont_left != 0 && b[7:6] == 2'b10) begin
      acc       = {acc[CpW-7:0], b[5:0]};
      cont_left = cont_left - 3'd1;
      if (cont_left == 0) begin
        c = acc;
        if (c < CpMinMulti) c = CpRepl;
        if (c == CpBom) begin
          // byte-order mark: swallowed
        end else if (c >= CpSurrLo && c <= CpSurrHi) begin
          if (c < CpTrailLo) begin
            lead_surr = c[15:0];
          end else begin
            v = (longint'(lead_surr) << 10) + longint'(c) + longint'(CpPlane1)
                - (longint'(CpSurrLo) << 10) - longint'(CpTrailLo);
            lead_surr = '0;
            add((v < longint'(CpPlane1)) ? CpRepl : v[CpW-1:0]);
          end
        end else begin
          add(c);
        end
      end
    end else begin
      if (cont_left != 0) add(CpRepl);
      casez (b)
        8'b110?_????: begin cont_left = 3'd1; acc = {26'd0, b[4:0]}; end
        8'b1110_????: begin cont_left = 3'd2; acc = {27'd0, b[3:0]}; end
        8'b1111_0???: begin cont_left = 3'd3; acc = {28'd0, b[2:0]}; end
        8'b1111_10??: begin cont_left = 3'd4; acc = {29'd0, b[1:0]}; end
        8'b1111_110?: begin cont_left = 3'd5; acc = {30'd0, b[0]}; end
        default: begin
          add(CpRepl);
          cont_left = '0;
        end
      endcase
    end
    if (run_q.size() > 0) run_q[run_q.size()-1].last = 1'b1;
    foreach (run_q[i]) expected_q.push_back(run_q[i]);
  endfunction

  function void check_word(logic [CpW-1:0] cp, logic last);
    utf8d_ent_t want;
    if (expected_q.size() == 0) begin
      $error("unexpected word: code_point %h last_in_run %b", cp, last);
      fail_count++;
      return;
    end
    want = expected_q.pop_front();
    if (cp !== want.cp) begin
      $error("code_point: expected %h, actual %h", want.cp, cp);
      fail_count++;
    end
    if (last !== want.last) begin
      $error("last_in_run: expected %b, actual %b", want.last, last);
      fail_count++;
    end
  endfunction
endclass

module utf8_stream_decoder_top_test;

  typedef enum logic [1:0] {
    StallNone,
    StallRandom,
    StallPeriodic
  } stall_mode_e;

  localparam int unsigned RandomWords = 800;

  logic           clk_i         = 1'b0;
  logic           rst_ni        = 1'b0;
  logic           in_valid_i    = 1'b0;
  logic           in_stall_o;
  logic [7:0]     data_byte_i   = 8'h00;
  logic           end_of_text_i = 1'b0;
  logic           out_valid_o;
  logic           out_stall_i   = 1'b0;
  logic [CpW-1:0] code_point_o;
  logic           last_in_run_o;

  cp_scoreboard sb = new();

  int unsigned words_sent = 0;
  int unsigned burst_left = 0;

  utf8_stream_decoder_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .end_of_text_i (end_of_text_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .code_point_o  (code_point_o),
    .last_in_run_o (last_in_run_o)
  );

  // 8 ns clock
  always #4 clk_i = ~clk_i;

  // Both handshakes are sampled at the edge, with the values that held just
  // before it. A word taken this edge only feeds results from the next one,
  // so the order of note and check within the edge does not matter.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_byte(data_byte_i, end_of_text_i);
      if (out_valid_o && !out_stall_i) sb.check_word(code_point_o, last_in_run_o);
    end
  end

  // Receiver back-pressure: hops between no stall, random stall and a
  // periodic stall pattern, each held for a random stretch of cycles.
  stall_mode_e stall_mode   = StallNone;
  int unsigned mode_left    = 0;
  int unsigned stall_period = 4;
  int unsigned stall_duty   = 1;
  int unsigned stall_phase  = 0;

  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      stall_mode   = stall_mode_e'($urandom_range(0, 2));
      mode_left    = $urandom_range(32, 256);
      stall_period = $urandom_range(2, 14);
      stall_duty   = $urandom_range(1, stall_period - 1);
      stall_phase  = 0;
    end
    mode_left--;
    stall_phase++;
    case (stall_mode)
      StallNone:   out_stall_i <= 1'b0;
      StallRandom: out_stall_i <= ($urandom_range(0, 99) < 40);
      default:     out_stall_i <= ((stall_phase % stall_period) < stall_duty);
    endcase
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Offer one byte word and hold it until taken. Bursts of random length,
  // separated by random idle gaps (sometimes none at all).
  task automatic send_word(input logic [7:0] b, input logic eot);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid_i    <= 1'b1;
    data_byte_i   <= b;
    end_of_text_i <= eot;
    do @(posedge clk_i); while (in_stall_o);
    burst_left--;
    words_sent++;
  endtask

  // Encode a value as a len-byte sequence and send the first keep bytes.
  task automatic send_char(input int unsigned len, input logic [CpW-1:0] value,
                           input int unsigned keep);
    logic [7:0] lead_prefix;
    logic [7:0] lead_mask;
    logic [7:0] chunk;
    if (len == 1) begin
      send_word({1'b0, value[6:0]}, 1'b0);
    end else begin
      lead_prefix = 8'hFF << (8 - len);
      lead_mask   = 8'hFF >> (len + 1);
      chunk       = 8'(value >> (6 * (len - 1)));
      send_word(lead_prefix | (chunk & lead_mask), 1'b0);
      for (int unsigned i = 1; i < keep; i++) begin
        chunk = 8'(value >> (6 * (len - 1 - i)));
        send_word(8'h80 | (chunk & 8'h3F), 1'b0);
      end
    end
  endtask

  // Idle the input until every predicted word has come out.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (sb.outstanding() != 0);
  endtask

  // Mostly well-formed text with random content; the rest overlong forms, surrogates,
  // byte-order marks, truncated sequences, noise bytes, zero bytes and end-of-text marks.
  task automatic random_text(input int unsigned n_words);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned len;
    bit          paused;
    stop_at = words_sent + n_words;
    paused  = 1'b0;
    while (words_sent < stop_at) begin
      if (!paused && words_sent >= stop_at - n_words / 2) begin
        drain_results();
        paused = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        send_char(1, 31'($urandom_range(1, 127)), 1);
      end else if (pick < 55) begin
        send_char(2, 31'($urandom & 32'h7FF), 2);
      end else if (pick < 70) begin
        send_char(3, 31'($urandom & 32'hFFFF), 3);
      end else if (pick < 76) begin
        // surrogate pair; now and then a lone half
        if ($urandom_range(0, 5) != 0)
          send_char(3, 31'(32'hD800 | ($urandom & 32'h3FF)), 3);
        if ($urandom_range(0, 5) != 0)
          send_char(3, 31'(32'hDC00 | ($urandom & 32'h3FF)), 3);
      end else if (pick < 79) begin
        send_char(3, CpBom, 3);
      end else if (pick < 85) begin
        send_char(4, 31'($urandom & 32'h1F_FFFF), 4);
      end else if (pick < 88) begin
        send_char(5, 31'($urandom & 32'h3FF_FFFF), 5);
      end else if (pick < 91) begin
        send_char(6, 31'($urandom), 6);
      end else if (pick < 95) begin
        len = $urandom_range(2, 6);
        send_char(len, 31'($urandom), $urandom_range(1, len - 1));
      end else if (pick < 98) begin
        send_word(8'($urandom), 1'b0);
      end else if (pick < 99) begin
        send_word(8'h00, 1'b0);
      end else begin
        send_word(8'($urandom), 1'b1);
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ASCII top and an overlong two-byte form (below 0xA0)
    send_word(8'h7F, 1'b0);
    send_word(8'hC1, 1'b0);
    send_word(8'h81, 1'b0);
    // byte-order mark is swallowed
    send_char(3, CpBom, 3);
    // surrogate pair -> U+1F600
    send_char(3, 31'h0000_D83D, 3);
    send_char(3, 31'h0000_DE00, 3);
    // stray continuation, then the two invalid lead bytes
    send_word(8'h80, 1'b0);
    send_word(8'hFE, 1'b0);
    send_word(8'hFF, 1'b0);
    // pending two-byte sequence cut off by a six-byte lead; top value
    send_word(8'hC3, 1'b0);
    send_char(6, 31'h7FFF_FFFF, 6);
    // end of text flushes a pending sequence
    send_word(8'hC3, 1'b0);
    send_word(8'($urandom), 1'b1);
    // zero byte clears the held lead; the trail then stands alone
    send_char(3, 31'h0000_DBFF, 3);
    send_word(8'h00, 1'b0);
    send_char(3, 31'h0000_DFFF, 3);
    drain_results();

    random_text(RandomWords);

    drain_results();
    repeat (4) @(posedge clk_i);
    if (sb.fail_count == 0 && sb.outstanding() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
